// ===== rtl/core/cstb_pkg.sv =====
package cstb_pkg;

    localparam longint unsigned BLOCK_BYTES   = 64'd65536;
    localparam int              POSITION_BITS = 32;

    localparam int CHAR_BITS      = 16;
    localparam int CAP_FIELD_BITS = 17;
    localparam int CFG_INDEX_BITS = 1;
    localparam int TAG_LEN        = 8;
    localparam int WIDTH_TAG_LEN  = 7;
    localparam int VALUE_TAG_LEN  = 7;
    localparam int CLASS_Q_DEPTH  = 4;
    localparam int RESULT_Q_DEPTH = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_CAPACITY = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_PRESENT  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL = 16'h0000;
    localparam logic [CHAR_BITS-1:0] CHAR_AMP = 16'h0026;

    localparam logic [CHAR_BITS-1:0] TOK_OFFSET [TAG_LEN] = '{
        16'h0026, 16'h004F, 16'h0046, 16'h0046, 16'h0053, 16'h0045, 16'h0054, 16'h003D
    };
    localparam logic [CHAR_BITS-1:0] TOK_WIDTH [WIDTH_TAG_LEN] = '{
        16'h0026, 16'h0057, 16'h0049, 16'h0044, 16'h0054, 16'h0048, 16'h003D
    };
    localparam logic [CHAR_BITS-1:0] TOK_VALUE [VALUE_TAG_LEN] = '{
        16'h0026, 16'h0056, 16'h0041, 16'h004C, 16'h0055, 16'h0045, 16'h003D
    };

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_OFF_HEX,
        PH_WID_TAG,
        PH_WID_HEX,
        PH_VAL_TAG,
        PH_DATA_HI,
        PH_DATA_LO
    } t_phase;

    // What the parser needs to know about one character.
    typedef struct packed {
        logic               is_nul;
        logic               is_amp;
        logic               is_hex;
        logic [3:0]         nibble;
        logic [TAG_LEN-1:0] off_match;
        logic [TAG_LEN-1:0] wid_match;
        logic [TAG_LEN-1:0] val_match;
    } t_class;

    typedef struct packed {
        logic                      we;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CAP_FIELD_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [63:0] required;
        logic [31:0] progress;
    } t_result;

endpackage

// ===== rtl/core/cstb_fifo.sv =====
module cstb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

endmodule

// ===== rtl/core/cstb_front.sv =====
module cstb_front (
    input  logic [cstb_pkg::CHAR_BITS-1:0] i_char,
    output cstb_pkg::t_class               o_class
);

    logic is_dig, is_upper, is_lower;

    assign is_dig   = (i_char >= 16'h0030) && (i_char <= 16'h0039);
    assign is_upper = (i_char >= 16'h0041) && (i_char <= 16'h0046);
    assign is_lower = (i_char >= 16'h0061) && (i_char <= 16'h0066);

    always_comb begin
        o_class.is_nul = (i_char == cstb_pkg::CHAR_NUL);
        o_class.is_amp = (i_char == cstb_pkg::CHAR_AMP);
        o_class.is_hex = is_dig || is_upper || is_lower;
        // Letters A-F and a-f both sit at 1..6 in their low nibble.
        o_class.nibble = is_dig ? i_char[3:0] : i_char[3:0] + 4'd9;
        for (int k = 0; k < cstb_pkg::TAG_LEN; k++) begin
            o_class.off_match[k] = (i_char == cstb_pkg::TOK_OFFSET[k]);
            o_class.wid_match[k] = 1'b0;
            o_class.val_match[k] = 1'b0;
        end
        for (int k = 0; k < cstb_pkg::WIDTH_TAG_LEN; k++) begin
            o_class.wid_match[k] = (i_char == cstb_pkg::TOK_WIDTH[k]);
        end
        for (int k = 0; k < cstb_pkg::VALUE_TAG_LEN; k++) begin
            o_class.val_match[k] = (i_char == cstb_pkg::TOK_VALUE[k]);
        end
    end

endmodule

// ===== rtl/core/cstb_back.sv =====
module cstb_back #(
    parameter longint unsigned BLOCK_BYTES   = cstb_pkg::BLOCK_BYTES,
    parameter int              POSITION_BITS = cstb_pkg::POSITION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cstb_pkg::t_cfg_wr i_cfg,
    input  cstb_pkg::t_class  i_class,
    input  logic              i_class_valid,
    output logic              o_class_take,
    input  logic              i_res_full,
    output logic              o_res_push,
    output cstb_pkg::t_result o_res
);

    localparam int PW = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam longint unsigned CAP_FIELD_MAX = (64'd1 << cstb_pkg::CAP_FIELD_BITS) - 64'd1;
    localparam longint unsigned CAP_MAX =
        (BLOCK_BYTES < CAP_FIELD_MAX) ? BLOCK_BYTES : CAP_FIELD_MAX;
    localparam int LEFT_BITS = (CAP_MAX > 1) ? $clog2(CAP_MAX + 1) : 1;

    logic [cstb_pkg::CAP_FIELD_BITS-1:0] r_capacity;
    logic                                r_present;

    cstb_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_tag, n_tag;
    logic [63:0]      r_acc, n_acc;
    logic             r_seen, n_seen;
    logic [63:0]      r_offset, n_offset;
    logic [63:0]      r_end, n_end;
    logic             r_wrap, n_wrap;
    logic             r_wzero, n_wzero;
    logic [LEFT_BITS-1:0] r_left, n_left;
    logic [15:0]      r_wptr, n_wptr;
    logic [3:0]       r_hi, n_hi;
    logic [63:0]      r_largest, n_largest;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_tag_pos, n_tag_pos;
    logic             r_discard, n_discard;

    logic [PW-1:0]        pos_nx;
    logic [LEFT_BITS-1:0] cap_eff;
    logic [64:0]          sum;
    logic [63:0]          max_end;
    logic                 too_small;
    logic                 fin;
    logic [1:0]           fin_status;
    logic [PW-1:0]        fin_prog;
    logic [63:0]          fin_req;

    assign o_class_take = i_class_valid && !i_res_full;
    assign pos_nx       = (&r_pos) ? r_pos : r_pos + 1'b1;
    assign cap_eff      = (r_capacity > cstb_pkg::CAP_FIELD_BITS'(CAP_MAX))
                        ? LEFT_BITS'(CAP_MAX) : LEFT_BITS'(r_capacity);
    assign sum          = {1'b0, r_offset} + {1'b0, r_acc};
    assign max_end      = (r_end > r_largest) ? r_end : r_largest;
    // Capacity short of max(end, largest) is short of either one.
    assign too_small    = !r_present || (64'(cap_eff) < r_end) || (64'(cap_eff) < r_largest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_present  <= 1'b1;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                cstb_pkg::CFG_BLOCK_CAPACITY: r_capacity <= i_cfg.data;
                cstb_pkg::CFG_BLOCK_PRESENT:  r_present  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_offset   = r_offset;
        n_end      = r_end;
        n_wrap     = r_wrap;
        n_wzero    = r_wzero;
        n_left     = r_left;
        n_wptr     = r_wptr;
        n_hi       = r_hi;
        n_largest  = r_largest;
        n_pos      = r_pos;
        n_tag_pos  = r_tag_pos;
        n_discard  = r_discard;
        fin        = 1'b0;
        fin_status = cstb_pkg::ST_OK;
        fin_prog   = r_pos;
        fin_req    = r_largest;
        o_res_push = 1'b0;
        o_res      = '0;

        if (o_class_take) begin
            if (r_discard) begin
                if (i_class.is_nul) begin
                    n_discard = 1'b0;
                end
            end else begin
                n_pos = pos_nx;
                unique case (r_phase)
                    cstb_pkg::PH_SEARCH: begin
                        if (i_class.is_nul) begin
                            fin = 1'b1;
                        end else if (i_class.off_match[r_tag]) begin
                            if (r_tag == 3'(cstb_pkg::TAG_LEN - 1)) begin
                                n_phase = cstb_pkg::PH_OFF_HEX;
                                n_tag   = '0;
                                n_acc   = '0;
                                n_seen  = 1'b0;
                            end else begin
                                n_tag = r_tag + 1'b1;
                            end
                        end else begin
                            n_tag = i_class.is_amp ? 3'd1 : 3'd0;
                        end
                    end
                    cstb_pkg::PH_OFF_HEX, cstb_pkg::PH_WID_HEX: begin
                        if (i_class.is_nul || i_class.is_amp) begin
                            if (!r_seen || i_class.is_nul) begin
                                fin        = 1'b1;
                                fin_status = cstb_pkg::ST_MALFORMED;
                            end else begin
                                if (r_phase == cstb_pkg::PH_OFF_HEX) begin
                                    n_offset = r_acc;
                                    n_phase  = cstb_pkg::PH_WID_TAG;
                                end else begin
                                    // The end sum is formed here, ahead of the size checks.
                                    n_end   = sum[63:0];
                                    n_wrap  = sum[64];
                                    n_wzero = (r_acc == '0);
                                    n_left  = LEFT_BITS'(r_acc);
                                    n_phase = cstb_pkg::PH_VAL_TAG;
                                end
                                n_tag     = 3'd1;
                                n_tag_pos = r_pos;
                            end
                        end else if (!i_class.is_hex || (|r_acc[63:60])) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                        end else begin
                            n_acc  = {r_acc[59:0], i_class.nibble};
                            n_seen = 1'b1;
                        end
                    end
                    cstb_pkg::PH_WID_TAG: begin
                        if (!i_class.wid_match[r_tag]) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                            fin_prog   = r_tag_pos;
                        end else if (r_tag == 3'(cstb_pkg::WIDTH_TAG_LEN - 1)) begin
                            n_phase = cstb_pkg::PH_WID_HEX;
                            n_tag   = '0;
                            n_acc   = '0;
                            n_seen  = 1'b0;
                        end else begin
                            n_tag = r_tag + 1'b1;
                        end
                    end
                    cstb_pkg::PH_VAL_TAG: begin
                        if (!i_class.val_match[r_tag]) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                            fin_prog   = r_tag_pos;
                        end else if (r_tag != 3'(cstb_pkg::VALUE_TAG_LEN - 1)) begin
                            n_tag = r_tag + 1'b1;
                        end else if (r_wrap) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                            fin_prog   = pos_nx;
                        end else if (too_small) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_TOO_SMALL;
                            fin_prog   = pos_nx;
                            fin_req    = max_end;
                        end else begin
                            n_largest = max_end;
                            n_tag     = '0;
                            if (r_wzero) begin
                                n_phase = cstb_pkg::PH_SEARCH;
                            end else begin
                                n_phase = cstb_pkg::PH_DATA_HI;
                                n_wptr  = r_offset[15:0];
                            end
                        end
                    end
                    cstb_pkg::PH_DATA_HI: begin
                        if (!i_class.is_hex) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                        end else begin
                            n_hi      = i_class.nibble;
                            n_tag_pos = r_pos;
                            n_phase   = cstb_pkg::PH_DATA_LO;
                        end
                    end
                    cstb_pkg::PH_DATA_LO: begin
                        if (!i_class.is_hex) begin
                            fin        = 1'b1;
                            fin_status = cstb_pkg::ST_MALFORMED;
                            fin_prog   = r_tag_pos;
                        end else begin
                            o_res_push    = 1'b1;
                            o_res.kind    = cstb_pkg::KIND_WRITE;
                            o_res.address = r_wptr;
                            o_res.data    = {r_hi, i_class.nibble};
                            n_wptr        = r_wptr + 1'b1;
                            n_left        = r_left - 1'b1;
                            if (r_left == LEFT_BITS'(1)) begin
                                n_phase = cstb_pkg::PH_SEARCH;
                                n_tag   = '0;
                            end else begin
                                n_phase = cstb_pkg::PH_DATA_HI;
                            end
                        end
                    end
                    default: begin
                        n_phase = cstb_pkg::PH_SEARCH;
                        n_tag   = '0;
                    end
                endcase

                if (fin) begin
                    o_res_push     = 1'b1;
                    o_res.kind     = cstb_pkg::KIND_REPORT;
                    o_res.status   = fin_status;
                    o_res.required = fin_req;
                    o_res.progress = 32'(fin_prog);
                    n_phase        = cstb_pkg::PH_SEARCH;
                    n_tag          = '0;
                    n_acc          = '0;
                    n_seen         = 1'b0;
                    n_offset       = '0;
                    n_end          = '0;
                    n_wrap         = 1'b0;
                    n_wzero        = 1'b0;
                    n_left         = '0;
                    n_wptr         = '0;
                    n_hi           = '0;
                    n_largest      = '0;
                    n_pos          = '0;
                    n_tag_pos      = '0;
                    n_discard      = !i_class.is_nul;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cstb_pkg::PH_SEARCH;
            r_tag     <= '0;
            r_seen    <= 1'b0;
            r_wrap    <= 1'b0;
            r_wzero   <= 1'b0;
            r_largest <= '0;
            r_pos     <= '0;
            r_tag_pos <= '0;
            r_discard <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_tag     <= n_tag;
            r_seen    <= n_seen;
            r_wrap    <= n_wrap;
            r_wzero   <= n_wzero;
            r_largest <= n_largest;
            r_pos     <= n_pos;
            r_tag_pos <= n_tag_pos;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_offset <= n_offset;
        r_end    <= n_end;
        r_left   <= n_left;
        r_wptr   <= n_wptr;
        r_hi     <= n_hi;
    end

endmodule

// ===== rtl/core/config_string_to_block_parser_unit.sv =====
// Streams a NUL-terminated configuration string one 16-bit character per beat and turns each
// &OFFSET=..&WIDTH=..&VALUE=.. group into byte-write results, ending every string with one
// completion report (status, largest offset+width, stop position). Throughput is one character
// per clock: a character is classified on the push side and lands in a four-entry queue, and
// the parser takes one classified character per cycle whenever the four-entry result queue has
// room. A result enters the result queue on the edge at which the parser takes its character.
// The input reports full only after the result queue has filled and four characters wait
// behind it. Characters that follow an early report are dropped at the same rate up to the
// next NUL. There is no clearing pass after reset; configuration writes take effect on the
// next clock.
module config_string_to_block_parser_unit #(
    parameter longint unsigned BLOCK_BYTES   = cstb_pkg::BLOCK_BYTES,
    parameter int              POSITION_BITS = cstb_pkg::POSITION_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [cstb_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [cstb_pkg::CAP_FIELD_BITS-1:0]      i_cfg_data,
    input  logic                                     push,
    output logic                                     full,
    input  logic [cstb_pkg::CHAR_BITS-1:0]           i_text_char,
    output logic                                     empty,
    input  logic                                     pop,
    output logic                                     o_result_kind,
    output logic [15:0]                              o_write_address,
    output logic [7:0]                               o_write_byte,
    output logic [1:0]                               o_status_code,
    output logic [63:0]                              o_required_size,
    output logic [31:0]                              o_progress_index
);

    localparam int CLASS_W  = $bits(cstb_pkg::t_class);
    localparam int RESULT_W = $bits(cstb_pkg::t_result);

    cstb_pkg::t_class  cls_in, cls_q;
    cstb_pkg::t_result res, res_q;
    cstb_pkg::t_cfg_wr cfg;
    logic [CLASS_W-1:0]  cls_dout;
    logic [RESULT_W-1:0] res_dout;
    logic cls_empty, cls_take, res_full, res_push;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    cstb_front u_front (
        .i_char  (i_text_char),
        .o_class (cls_in)
    );

    cstb_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (cstb_pkg::CLASS_Q_DEPTH)
    ) u_class_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (cls_in),
        .o_full  (full),
        .i_pop   (cls_take),
        .o_dout  (cls_dout),
        .o_empty (cls_empty)
    );

    assign cls_q = cls_dout;

    cstb_back #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_class       (cls_q),
        .i_class_valid (!cls_empty),
        .o_class_take  (cls_take),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res)
    );

    cstb_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (cstb_pkg::RESULT_Q_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_din   (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_dout  (res_dout),
        .o_empty (empty)
    );

    assign res_q            = res_dout;
    assign o_result_kind    = res_q.kind;
    assign o_write_address  = res_q.address;
    assign o_write_byte     = res_q.data;
    assign o_status_code    = res_q.status;
    assign o_required_size  = res_q.required;
    assign o_progress_index = res_q.progress;

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result beat produced while the result queue is full");

    a_res_needs_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> cls_take)
        else $error("result beat produced without a character taken");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == cstb_pkg::KIND_WRITE) |->
            (o_status_code == cstb_pkg::ST_OK && o_required_size == '0
             && o_progress_index == '0))
        else $error("byte write beat carries report fields");

endmodule
